// ===== sv/lmr_pkg.sv =====
`default_nettype none

package lmr_pkg;

    // field widths of the request, result and configuration beats
    localparam int COMMAND_W = 1;
    localparam int CLIENT_W  = 6;
    localparam int SEQ_W     = 31;
    localparam int LOCK_W    = 8;
    localparam int KIND_W    = 2;
    localparam int STATUS_W  = 2;
    localparam int QLEN_W    = 5;
    localparam int THRESH_W  = 5;

    // table sizing defaults
    localparam int LOCK_COUNT_DEF  = 256;
    localparam int QUEUE_DEPTH_DEF = 16;

    localparam logic [THRESH_W-1:0] THRESH_RESET = 5'd5;

    localparam logic [COMMAND_W-1:0] CMD_ACQUIRE = 1'b0;
    localparam logic [COMMAND_W-1:0] CMD_RELEASE = 1'b1;

    localparam logic [KIND_W-1:0] KIND_REPLY  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REVOKE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RETRY  = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_RETRY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

endpackage

`default_nettype wire

// ===== sv/lmr_if.sv =====
`default_nettype none

interface lmr_req_if;
    logic                             valid;
    logic                             ready;
    logic [lmr_pkg::COMMAND_W-1:0]    command;
    logic [lmr_pkg::CLIENT_W-1:0]     client;
    logic [lmr_pkg::SEQ_W-1:0]        seq;
    logic [lmr_pkg::LOCK_W-1:0]       lock_id;

    modport source (output valid, command, client, seq, lock_id, input ready);
    modport sink   (input valid, command, client, seq, lock_id, output ready);
endinterface

interface lmr_rsp_if;
    logic                             valid;
    logic                             ready;
    logic [lmr_pkg::KIND_W-1:0]       kind;
    logic [lmr_pkg::STATUS_W-1:0]     status;
    logic [lmr_pkg::QLEN_W-1:0]       queue_length;
    logic [lmr_pkg::CLIENT_W-1:0]     target_client;
    logic [lmr_pkg::SEQ_W-1:0]        target_seq;
    logic [lmr_pkg::LOCK_W-1:0]       target_lock;
    logic                             last;

    modport source (output valid, kind, status, queue_length, target_client, target_seq,
                    target_lock, last, input ready);
    modport sink   (input valid, kind, status, queue_length, target_client, target_seq,
                    target_lock, last, output ready);
endinterface

interface lmr_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [lmr_pkg::THRESH_W-1:0]     revoke_skip_threshold;

    modport source (output valid, revoke_skip_threshold, input ready);
    modport sink   (input valid, revoke_skip_threshold, output ready);
endinterface

`default_nettype wire

// ===== sv/lmr_ram.sv =====
`default_nettype none

module lmr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// ===== sv/lock_manager_revoke_retry.sv =====
`default_nettype none

// channel | dir | beat carries
// --------+-----+-----------------------------------------------------------
// req     | in  | command, client, seq, lock_id
// rsp     | out | kind, status, queue_length, target_client, target_seq,
//         |     | target_lock, last
// cfg     | in  | revoke_skip_threshold
//
// one request at a time; a reply passes through the lock entry memory read and the
// single output register, a revoke adds the message step, and a release that pops
// a waiter also takes the waiter memory read before its message.
// after reset every entry of the entry memory is cleared in turn, req not ready.
// a stalled rsp holds the request in its lookup or message step; cfg always ready.

module lock_manager_revoke_retry #(
    parameter int LOCK_COUNT  = lmr_pkg::LOCK_COUNT_DEF,
    parameter int QUEUE_DEPTH = lmr_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    lmr_req_if.sink    req,
    lmr_rsp_if.source  rsp,
    lmr_cfg_if.sink    cfg
);

    localparam int LID_W  = $clog2(LOCK_COUNT);
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int HEAD_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int SUM_W  = CNT_W + 1;
    localparam int WDEPTH = LOCK_COUNT * QUEUE_DEPTH;
    localparam int WA_W   = $clog2(WDEPTH);
    localparam int WW_W   = lmr_pkg::CLIENT_W + lmr_pkg::SEQ_W;

    typedef struct packed {
        logic                          own_v;
        logic [lmr_pkg::CLIENT_W-1:0]  own_c;
        logic [lmr_pkg::SEQ_W-1:0]     own_s;
        logic                          exp_v;
        logic [lmr_pkg::CLIENT_W-1:0]  exp_c;
        logic                          rev;
        logic [CNT_W-1:0]              cnt;
        logic [HEAD_W-1:0]             head;
    } entry_t;

    localparam int ENT_W = $bits(entry_t);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_LOOK  = 5'b00100,
        S_POP   = 5'b01000,
        S_MSG   = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    logic [LID_W-1:0]                clr_reg;
    logic [lmr_pkg::THRESH_W-1:0]    thresh_reg;

    logic [lmr_pkg::COMMAND_W-1:0]   cmd_reg;
    logic [lmr_pkg::CLIENT_W-1:0]    client_reg;
    logic [lmr_pkg::SEQ_W-1:0]       seq_reg;
    logic [LID_W-1:0]                lid_reg;
    logic [lmr_pkg::LOCK_W-1:0]      lock_in_reg;

    entry_t                          ent_reg;
    logic [lmr_pkg::KIND_W-1:0]      msg_kind_reg;
    logic [lmr_pkg::CLIENT_W-1:0]    msg_client_reg;
    logic [lmr_pkg::SEQ_W-1:0]       msg_seq_reg;

    logic                            out_valid_reg;
    logic [lmr_pkg::KIND_W-1:0]      out_kind_reg;
    logic [lmr_pkg::STATUS_W-1:0]    out_status_reg;
    logic [lmr_pkg::QLEN_W-1:0]      out_qlen_reg;
    logic [lmr_pkg::CLIENT_W-1:0]    out_client_reg;
    logic [lmr_pkg::SEQ_W-1:0]       out_seq_reg;
    logic [lmr_pkg::LOCK_W-1:0]      out_lock_reg;
    logic                            out_last_reg;

    logic [lmr_pkg::LOCK_W-1:0]      lid_rem;
    logic [LID_W-1:0]                lid_in;

    logic                            ent_wr_en;
    logic [LID_W-1:0]                ent_wr_addr;
    logic [ENT_W-1:0]                ent_wr_data;
    logic                            ent_rd_en;
    logic [ENT_W-1:0]                ent_rd_data;

    logic                            wt_wr_en;
    logic [WA_W-1:0]                 wt_wr_addr;
    logic                            wt_rd_en;
    logic [WA_W-1:0]                 wt_rd_addr;
    logic [WW_W-1:0]                 wt_rd_data;

    entry_t                          e_cur;
    entry_t                          ent_new;
    entry_t                          ent_pop;
    logic [CNT_W-1:0]                qlen;
    logic                            grant;
    logic                            do_enq;
    logic                            do_pop;
    logic                            msg_need;
    logic [lmr_pkg::KIND_W-1:0]      msg_kind;
    logic [lmr_pkg::CLIENT_W-1:0]    msg_client;
    logic [lmr_pkg::SEQ_W-1:0]       msg_seq;
    logic [lmr_pkg::STATUS_W-1:0]    rep_status;
    logic [lmr_pkg::QLEN_W-1:0]      rep_qlen;
    logic [SUM_W-1:0]                slot_sum;
    logic [HEAD_W-1:0]               enq_slot;
    logic [WA_W-1:0]                 wt_base;

    logic                            slot_free;
    logic                            look_go;
    logic                            msg_go;

    // lock id reduced modulo the table size by conditional subtraction
    always_comb
    begin
        lid_rem = req.lock_id;
        for (int k = lmr_pkg::LOCK_W - 1; k >= 0; k--)
        begin
            if (32'(lid_rem) >= (LOCK_COUNT << k))
            begin
                lid_rem = lid_rem - lmr_pkg::LOCK_W'(LOCK_COUNT << k);
            end
        end
    end

    assign lid_in = LID_W'(lid_rem);

    assign slot_free = !out_valid_reg || rsp.ready;
    assign look_go   = (state_reg == S_LOOK) && slot_free;
    assign msg_go    = (state_reg == S_MSG) && slot_free;

    // decision on the entry read back for the held request
    always_comb
    begin
        e_cur      = entry_t'(ent_rd_data);
        ent_new    = e_cur;
        qlen       = e_cur.cnt;
        grant      = !e_cur.own_v && ((qlen == '0) || (e_cur.exp_v && e_cur.exp_c == client_reg));
        do_enq     = 1'b0;
        do_pop     = 1'b0;
        msg_need   = 1'b0;
        msg_kind   = lmr_pkg::KIND_REVOKE;
        msg_client = client_reg;
        msg_seq    = seq_reg;
        rep_status = lmr_pkg::STATUS_OK;
        rep_qlen   = lmr_pkg::QLEN_W'(qlen);
        if (cmd_reg == lmr_pkg::CMD_ACQUIRE)
        begin
            if (grant)
            begin
                ent_new.own_v = 1'b1;
                ent_new.own_c = client_reg;
                ent_new.own_s = seq_reg;
                if (qlen != '0)
                begin
                    ent_new.exp_v = 1'b0;
                    ent_new.rev   = 1'b1;
                    msg_need      = 32'(qlen) < 32'(thresh_reg);
                end
                else
                begin
                    ent_new.rev = 1'b0;
                end
            end
            else if (qlen >= CNT_W'(QUEUE_DEPTH))
            begin
                rep_status = lmr_pkg::STATUS_FULL;
            end
            else
            begin
                do_enq      = 1'b1;
                ent_new.cnt = qlen + CNT_W'(1);
                rep_status  = lmr_pkg::STATUS_RETRY;
                // first waiter asks the owner to give the lock back, once
                if ((qlen == '0) && !e_cur.rev && e_cur.own_v)
                begin
                    ent_new.rev = 1'b1;
                    msg_need    = 1'b1;
                    msg_client  = e_cur.own_c;
                    msg_seq     = e_cur.own_s;
                end
            end
        end
        else
        begin
            rep_qlen = '0;
            if (e_cur.own_v && (e_cur.own_c == client_reg))
            begin
                ent_new.own_v = 1'b0;
                ent_new.own_c = '0;
                ent_new.own_s = '0;
                if (qlen != '0)
                begin
                    do_pop        = 1'b1;
                    msg_need      = 1'b1;
                    msg_kind      = lmr_pkg::KIND_RETRY;
                    ent_new.cnt   = qlen - CNT_W'(1);
                    ent_new.exp_v = 1'b1;
                    ent_new.head  = (32'(e_cur.head) == QUEUE_DEPTH - 1) ? '0
                                    : e_cur.head + HEAD_W'(1);
                end
            end
        end
    end

    always_comb
    begin
        slot_sum = SUM_W'(e_cur.head) + SUM_W'(qlen);
        if (32'(slot_sum) >= QUEUE_DEPTH)
        begin
            slot_sum = slot_sum - SUM_W'(QUEUE_DEPTH);
        end
        enq_slot = HEAD_W'(slot_sum);
    end

    assign wt_base    = WA_W'(lid_reg) * WA_W'(QUEUE_DEPTH);
    assign wt_wr_en   = look_go && do_enq;
    assign wt_wr_addr = wt_base + WA_W'(enq_slot);
    assign wt_rd_en   = look_go && do_pop;
    assign wt_rd_addr = wt_base + WA_W'(e_cur.head);

    // popped waiter becomes the expected retrier
    always_comb
    begin
        ent_pop       = ent_reg;
        ent_pop.exp_c = wt_rd_data[WW_W-1 -: lmr_pkg::CLIENT_W];
    end

    assign ent_rd_en = (state_reg == S_IDLE) && req.valid;

    always_comb
    begin
        ent_wr_en   = 1'b0;
        ent_wr_addr = lid_reg;
        ent_wr_data = ent_new;
        case (state_reg)
            S_CLEAR:
            begin
                ent_wr_en   = 1'b1;
                ent_wr_addr = clr_reg;
                ent_wr_data = '0;
            end
            S_LOOK:
            begin
                ent_wr_en = look_go && !do_pop;
            end
            S_POP:
            begin
                ent_wr_en   = 1'b1;
                ent_wr_data = ent_pop;
            end
            default:
            begin
                ent_wr_en = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_CLEAR:
            begin
                if (32'(clr_reg) == LOCK_COUNT - 1)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req.valid)
                begin
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                if (slot_free)
                begin
                    if (do_pop)
                    begin
                        state_next = S_POP;
                    end
                    else if (msg_need)
                    begin
                        state_next = S_MSG;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            S_POP:
            begin
                state_next = S_MSG;
            end
            S_MSG:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    lmr_ram #(
        .WIDTH (ENT_W),
        .DEPTH (LOCK_COUNT)
    ) u_entry_ram (
        .clk     (clk),
        .wr_en   (ent_wr_en),
        .wr_addr (ent_wr_addr),
        .wr_data (ent_wr_data),
        .rd_en   (ent_rd_en),
        .rd_addr (lid_in),
        .rd_data (ent_rd_data)
    );

    lmr_ram #(
        .WIDTH (WW_W),
        .DEPTH (WDEPTH)
    ) u_waiter_ram (
        .clk     (clk),
        .wr_en   (wt_wr_en),
        .wr_addr (wt_wr_addr),
        .wr_data ({client_reg, seq_reg}),
        .rd_en   (wt_rd_en),
        .rd_addr (wt_rd_addr),
        .rd_data (wt_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            thresh_reg    <= lmr_pkg::THRESH_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
            begin
                clr_reg <= clr_reg + LID_W'(1);
            end
            if (cfg.valid)
            begin
                thresh_reg <= cfg.revoke_skip_threshold;
            end
            if (look_go || msg_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ent_rd_en)
        begin
            cmd_reg     <= req.command;
            client_reg  <= req.client;
            seq_reg     <= req.seq;
            lid_reg     <= lid_in;
            lock_in_reg <= req.lock_id;
        end
        if (look_go)
        begin
            ent_reg        <= ent_new;
            msg_kind_reg   <= msg_kind;
            msg_client_reg <= msg_client;
            msg_seq_reg    <= msg_seq;
            out_kind_reg   <= lmr_pkg::KIND_REPLY;
            out_status_reg <= rep_status;
            out_qlen_reg   <= rep_qlen;
            out_client_reg <= '0;
            out_seq_reg    <= '0;
            out_lock_reg   <= lock_in_reg;
            out_last_reg   <= !msg_need;
        end
        if (state_reg == S_POP)
        begin
            msg_client_reg <= wt_rd_data[WW_W-1 -: lmr_pkg::CLIENT_W];
            msg_seq_reg    <= wt_rd_data[lmr_pkg::SEQ_W-1:0];
        end
        if (msg_go)
        begin
            out_kind_reg   <= msg_kind_reg;
            out_status_reg <= lmr_pkg::STATUS_OK;
            out_qlen_reg   <= '0;
            out_client_reg <= msg_client_reg;
            out_seq_reg    <= msg_seq_reg;
            out_lock_reg   <= lock_in_reg;
            out_last_reg   <= 1'b1;
        end
    end

    assign req.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;

    assign rsp.valid         = out_valid_reg;
    assign rsp.kind          = out_kind_reg;
    assign rsp.status        = out_status_reg;
    assign rsp.queue_length  = out_qlen_reg;
    assign rsp.target_client = out_client_reg;
    assign rsp.target_seq    = out_seq_reg;
    assign rsp.target_lock   = out_lock_reg;
    assign rsp.last          = out_last_reg;

endmodule

`default_nettype wire

// ===== tb/sv/lock_manager_revoke_retry_tb.sv =====
`default_nettype none

module lock_manager_revoke_retry_tb;

    localparam int LOCKS            = lmr_pkg::LOCK_COUNT_DEF;
    localparam int QDEPTH           = lmr_pkg::QUEUE_DEPTH_DEF;
    localparam int CYCLE_LIMIT      = 200000;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int TAIL_CYCLES      = 12;
    localparam int PHASE_ITEMS      = 160;
    localparam logic [lmr_pkg::SEQ_W-1:0] SEQ_MAX = {lmr_pkg::SEQ_W{1'b1}};

    typedef struct packed {
        logic [lmr_pkg::KIND_W-1:0]   kind;
        logic [lmr_pkg::STATUS_W-1:0] status;
        logic [lmr_pkg::QLEN_W-1:0]   qlen;
        logic [lmr_pkg::CLIENT_W-1:0] tclient;
        logic [lmr_pkg::SEQ_W-1:0]    tseq;
        logic [lmr_pkg::LOCK_W-1:0]   tlock;
        logic                         last;
    } lock_msg_t;

    // one directed request; reps > 1 repeats it with client and seq stepped
    typedef struct packed {
        logic [lmr_pkg::COMMAND_W-1:0] cmd;
        logic [lmr_pkg::CLIENT_W-1:0]  client;
        logic [lmr_pkg::SEQ_W-1:0]     seq;
        logic [lmr_pkg::LOCK_W-1:0]    lock_id;
        logic [4:0]                    reps;
        logic                          typed;
        logic [lmr_pkg::STATUS_W-1:0]  t_status;
        logic [lmr_pkg::QLEN_W-1:0]    t_qlen;
        logic                          t_msg;
    } lock_row_t;

    logic clk;
    logic rst_n;

    lmr_req_if req_ch ();
    lmr_rsp_if rsp_ch ();
    lmr_cfg_if cfg_ch ();

    lock_manager_revoke_retry u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    // lock table as the testbench sees it
    logic                         tbl_own_v      [LOCKS];
    logic [lmr_pkg::CLIENT_W-1:0] tbl_own_client [LOCKS];
    logic [lmr_pkg::SEQ_W-1:0]    tbl_own_seq    [LOCKS];
    logic                         tbl_exp_v      [LOCKS];
    logic [lmr_pkg::CLIENT_W-1:0] tbl_exp_client [LOCKS];
    logic                         tbl_rev_sent   [LOCKS];
    logic [lmr_pkg::QLEN_W-1:0]   tbl_wait_cnt   [LOCKS];
    logic [3:0]                   tbl_wait_head  [LOCKS];
    logic [lmr_pkg::CLIENT_W-1:0] tbl_wq_client  [LOCKS*QDEPTH];
    logic [lmr_pkg::SEQ_W-1:0]    tbl_wq_seq     [LOCKS*QDEPTH];
    logic [lmr_pkg::THRESH_W-1:0] skip_thresh;

    lock_msg_t due_msgs [$];
    lock_msg_t head_msg;
    lock_row_t dir_rows [$];

    int  err_count   = 0;
    int  cycle_count = 0;
    int  sent_items  = 0;
    bit  send_idle   = 1'b1;
    bit  rsp_idle    = 1'b1;
    bit  long_hold   = 1'b0;

    logic [lmr_pkg::LOCK_W-1:0]   lock_pool   [4];
    logic [lmr_pkg::CLIENT_W-1:0] client_pool [6];

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("lock_manager_revoke_retry_tb: done, errors");
            $finish;
        end
    end

    function automatic lock_msg_t lock_msg(input logic [lmr_pkg::KIND_W-1:0] kind,
                                           input logic [lmr_pkg::STATUS_W-1:0] status,
                                           input logic [lmr_pkg::QLEN_W-1:0] qlen,
                                           input logic [lmr_pkg::CLIENT_W-1:0] tclient,
                                           input logic [lmr_pkg::SEQ_W-1:0] tseq,
                                           input logic [lmr_pkg::LOCK_W-1:0] tlock,
                                           input logic last);
        lock_msg_t m;
        m.kind    = kind;
        m.status  = status;
        m.qlen    = qlen;
        m.tclient = tclient;
        m.tseq    = tseq;
        m.tlock   = tlock;
        m.last    = last;
        return m;
    endfunction

    function automatic lock_row_t lock_row(input logic [lmr_pkg::COMMAND_W-1:0] cmd,
                                           input logic [lmr_pkg::CLIENT_W-1:0] client,
                                           input logic [lmr_pkg::SEQ_W-1:0] seq,
                                           input logic [lmr_pkg::LOCK_W-1:0] lock_id,
                                           input logic [4:0] reps,
                                           input logic typed,
                                           input logic [lmr_pkg::STATUS_W-1:0] t_status,
                                           input logic [lmr_pkg::QLEN_W-1:0] t_qlen,
                                           input logic t_msg);
        lock_row_t r;
        r.cmd      = cmd;
        r.client   = client;
        r.seq      = seq;
        r.lock_id  = lock_id;
        r.reps     = reps;
        r.typed    = typed;
        r.t_status = t_status;
        r.t_qlen   = t_qlen;
        r.t_msg    = t_msg;
        return r;
    endfunction

    function automatic void add_row(input lock_row_t r);
        dir_rows.insert(dir_rows.size(), r);
    endfunction

    function automatic void expect_beat(input lock_msg_t m);
        due_msgs.insert(due_msgs.size(), m);
    endfunction

    function automatic void lock_table_clear();
        skip_thresh = lmr_pkg::THRESH_RESET;
        for (int i = 0; i < LOCKS; i++)
        begin
            tbl_own_v[i]      = 1'b0;
            tbl_own_client[i] = '0;
            tbl_own_seq[i]    = '0;
            tbl_exp_v[i]      = 1'b0;
            tbl_exp_client[i] = '0;
            tbl_rev_sent[i]   = 1'b0;
            tbl_wait_cnt[i]   = '0;
            tbl_wait_head[i]  = '0;
        end
        for (int i = 0; i < LOCKS*QDEPTH; i++)
        begin
            tbl_wq_client[i] = '0;
            tbl_wq_seq[i]    = '0;
        end
    endfunction

    // applies one request to the table and queues the beats it should produce
    function automatic void lock_table_step(input logic [lmr_pkg::COMMAND_W-1:0] cmd,
                                            input logic [lmr_pkg::CLIENT_W-1:0] cl,
                                            input logic [lmr_pkg::SEQ_W-1:0] sq,
                                            input logic [lmr_pkg::LOCK_W-1:0] lk);
        int                           lid;
        int                           base;
        int                           slot;
        logic [lmr_pkg::QLEN_W-1:0]   qlen;
        logic [lmr_pkg::CLIENT_W-1:0] wc;
        logic [lmr_pkg::SEQ_W-1:0]    ws;
        lid  = int'(lk) % LOCKS;
        base = lid * QDEPTH;
        qlen = tbl_wait_cnt[lid];

        if (cmd == lmr_pkg::CMD_ACQUIRE)
        begin
            if (!tbl_own_v[lid] &&
                (qlen == 0 || (tbl_exp_v[lid] && tbl_exp_client[lid] == cl)))
            begin
                tbl_own_v[lid]      = 1'b1;
                tbl_own_client[lid] = cl;
                tbl_own_seq[lid]    = sq;
                if (qlen != 0)
                begin
                    tbl_exp_v[lid]    = 1'b0;
                    tbl_rev_sent[lid] = 1'b1;
                    if (qlen < skip_thresh)
                    begin
                        expect_beat(lock_msg(lmr_pkg::KIND_REPLY, lmr_pkg::STATUS_OK, qlen,
                                             '0, '0, lk, 1'b0));
                        expect_beat(lock_msg(lmr_pkg::KIND_REVOKE, lmr_pkg::STATUS_OK, '0,
                                             cl, sq, lk, 1'b1));
                        return;
                    end
                end
                else
                begin
                    tbl_rev_sent[lid] = 1'b0;
                end
                expect_beat(lock_msg(lmr_pkg::KIND_REPLY, lmr_pkg::STATUS_OK, qlen,
                                     '0, '0, lk, 1'b1));
                return;
            end
            if (qlen >= QDEPTH)
            begin
                expect_beat(lock_msg(lmr_pkg::KIND_REPLY, lmr_pkg::STATUS_FULL, qlen,
                                     '0, '0, lk, 1'b1));
                return;
            end
            slot = base + (int'(tbl_wait_head[lid]) + int'(qlen)) % QDEPTH;
            tbl_wq_client[slot] = cl;
            tbl_wq_seq[slot]    = sq;
            tbl_wait_cnt[lid]   = qlen + 1'b1;
            // first waiter on a held lock asks the owner to give it up, once
            if (qlen == 0 && !tbl_rev_sent[lid] && tbl_own_v[lid])
            begin
                tbl_rev_sent[lid] = 1'b1;
                expect_beat(lock_msg(lmr_pkg::KIND_REPLY, lmr_pkg::STATUS_RETRY, qlen,
                                     '0, '0, lk, 1'b0));
                expect_beat(lock_msg(lmr_pkg::KIND_REVOKE, lmr_pkg::STATUS_OK, '0,
                                     tbl_own_client[lid], tbl_own_seq[lid], lk, 1'b1));
                return;
            end
            expect_beat(lock_msg(lmr_pkg::KIND_REPLY, lmr_pkg::STATUS_RETRY, qlen,
                                 '0, '0, lk, 1'b1));
            return;
        end

        if (tbl_own_v[lid] && tbl_own_client[lid] == cl)
        begin
            tbl_own_v[lid]      = 1'b0;
            tbl_own_client[lid] = '0;
            tbl_own_seq[lid]    = '0;
            if (qlen != 0)
            begin
                wc = tbl_wq_client[base + int'(tbl_wait_head[lid])];
                ws = tbl_wq_seq[base + int'(tbl_wait_head[lid])];
                tbl_wait_head[lid]  = tbl_wait_head[lid] + 1'b1;
                tbl_wait_cnt[lid]   = qlen - 1'b1;
                tbl_exp_v[lid]      = 1'b1;
                tbl_exp_client[lid] = wc;
                expect_beat(lock_msg(lmr_pkg::KIND_REPLY, lmr_pkg::STATUS_OK, '0,
                                     '0, '0, lk, 1'b0));
                expect_beat(lock_msg(lmr_pkg::KIND_RETRY, lmr_pkg::STATUS_OK, '0,
                                     wc, ws, lk, 1'b1));
                return;
            end
        end
        expect_beat(lock_msg(lmr_pkg::KIND_REPLY, lmr_pkg::STATUS_OK, '0, '0, '0, lk, 1'b1));
    endfunction

    // offers one request beat, waits for it to be taken, then predicts
    task automatic offer(input logic [lmr_pkg::COMMAND_W-1:0] cmd,
                         input logic [lmr_pkg::CLIENT_W-1:0] cl,
                         input logic [lmr_pkg::SEQ_W-1:0] sq,
                         input logic [lmr_pkg::LOCK_W-1:0] lk,
                         input logic typed, input logic [lmr_pkg::STATUS_W-1:0] t_status,
                         input logic [lmr_pkg::QLEN_W-1:0] t_qlen, input logic t_msg);
        int gap;
        int at;
        sent_items++;
        if (sent_items % 40 == 0)
            send_idle = ($urandom_range(0, 3) != 0);
        gap = send_idle ? $urandom_range(0, 6) : 0;
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.command <= cmd;
        req_ch.client  <= cl;
        req_ch.seq     <= sq;
        req_ch.lock_id <= lk;
        req_ch.valid   <= 1'b1;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        at = due_msgs.size();
        lock_table_step(cmd, cl, sq, lk);
        if (typed)
            due_msgs[at] = lock_msg(lmr_pkg::KIND_REPLY, t_status, t_qlen, '0, '0, lk, !t_msg);
    endtask

    // sender stops until every beat it is owed has come back
    task automatic settle();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (due_msgs.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic write_threshold(input logic [lmr_pkg::THRESH_W-1:0] v);
        cfg_ch.revoke_skip_threshold <= v;
        cfg_ch.valid                 <= 1'b1;
        @(posedge clk);
        while (!cfg_ch.ready)
            @(posedge clk);
        skip_thresh = v;
        cfg_ch.valid <= 1'b0;
    endtask

    function automatic logic [lmr_pkg::SEQ_W-1:0] pick_seq();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0)
            return '0;
        if (r == 1)
            return SEQ_MAX;
        return lmr_pkg::SEQ_W'($urandom);
    endfunction

    // mostly owner releases, retrier follow-ups and contention on a few locks
    task automatic run_mix(input int n_items, input int rel_pct);
        int                            r;
        logic [lmr_pkg::LOCK_W-1:0]    lk;
        logic [lmr_pkg::CLIENT_W-1:0]  cl;
        logic [lmr_pkg::COMMAND_W-1:0] cmd;
        for (int k = 0; k < 4; k++)
            lock_pool[k] = lmr_pkg::LOCK_W'($urandom_range(0, 255));
        for (int k = 0; k < 6; k++)
            client_pool[k] = lmr_pkg::CLIENT_W'($urandom_range(0, 63));
        for (int n = 0; n < n_items; n++)
        begin
            r  = $urandom_range(0, 99);
            lk = lock_pool[$urandom_range(0, 3)];
            cl = client_pool[$urandom_range(0, 5)];
            if (r < 8)
            begin
                cmd = $urandom_range(0, 1) ? lmr_pkg::CMD_RELEASE : lmr_pkg::CMD_ACQUIRE;
                cl  = lmr_pkg::CLIENT_W'($urandom_range(0, 63));
                lk  = lmr_pkg::LOCK_W'($urandom_range(0, 255));
            end
            else if (tbl_exp_v[lk] && !tbl_own_v[lk] && r < 45)
            begin
                cmd = lmr_pkg::CMD_ACQUIRE;
                cl  = tbl_exp_client[lk];
            end
            else if (r < 8 + rel_pct)
            begin
                cmd = lmr_pkg::CMD_RELEASE;
                if (tbl_own_v[lk] && r < 4 + rel_pct)
                    cl = tbl_own_client[lk];
            end
            else
            begin
                cmd = lmr_pkg::CMD_ACQUIRE;
            end
            offer(cmd, cl, pick_seq(), lk, 1'b0, lmr_pkg::STATUS_OK, '0, 1'b0);
        end
    endtask

    // result sink: random stalls per beat, plus one long hold-off on request
    initial
    begin
        int stall;
        int beats;
        beats = 0;
        rsp_ch.ready <= 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (long_hold)
            begin
                long_hold = 1'b0;
                rsp_ch.ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
            end
            beats++;
            if (beats % 50 == 0)
                rsp_idle = ($urandom_range(0, 3) != 0);
            stall = rsp_idle ? $urandom_range(0, 6) : 0;
            if (stall > 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_ch.ready <= 1'b1;
            @(posedge clk);
            while (!rsp_ch.valid)
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (due_msgs.size() == 0)
            begin
                err_count++;
                $error("result beat with nothing outstanding: kind %0d lock %0d",
                       rsp_ch.kind, rsp_ch.target_lock);
            end
            else
            begin
                head_msg = due_msgs[0];
                due_msgs.delete(0);
                if (rsp_ch.kind !== head_msg.kind)
                begin
                    err_count++;
                    $error("kind: expected %0d, got %0d", head_msg.kind, rsp_ch.kind);
                end
                if (rsp_ch.status !== head_msg.status)
                begin
                    err_count++;
                    $error("status: expected %0d, got %0d", head_msg.status, rsp_ch.status);
                end
                if (rsp_ch.queue_length !== head_msg.qlen)
                begin
                    err_count++;
                    $error("queue_length: expected %0d, got %0d", head_msg.qlen,
                           rsp_ch.queue_length);
                end
                if (rsp_ch.target_client !== head_msg.tclient)
                begin
                    err_count++;
                    $error("target_client: expected %0d, got %0d", head_msg.tclient,
                           rsp_ch.target_client);
                end
                if (rsp_ch.target_seq !== head_msg.tseq)
                begin
                    err_count++;
                    $error("target_seq: expected %0d, got %0d", head_msg.tseq,
                           rsp_ch.target_seq);
                end
                if (rsp_ch.target_lock !== head_msg.tlock)
                begin
                    err_count++;
                    $error("target_lock: expected %0d, got %0d", head_msg.tlock,
                           rsp_ch.target_lock);
                end
                if (rsp_ch.last !== head_msg.last)
                begin
                    err_count++;
                    $error("last: expected %0d, got %0d", head_msg.last, rsp_ch.last);
                end
            end
        end
    end

    initial
    begin
        logic [lmr_pkg::THRESH_W-1:0] phase_thresh [6];
        int                           phase_rel    [6];
        lock_row_t                    row;

        rst_n                        <= 1'b0;
        req_ch.valid                 <= 1'b0;
        req_ch.command               <= lmr_pkg::CMD_ACQUIRE;
        req_ch.client                <= '0;
        req_ch.seq                   <= '0;
        req_ch.lock_id               <= '0;
        cfg_ch.valid                 <= 1'b0;
        cfg_ch.revoke_skip_threshold <= '0;
        lock_table_clear();

        // lock 0: queueing, revoke to owner, retry on release, retrier grant
        add_row(lock_row(lmr_pkg::CMD_ACQUIRE, 0, 0, 0, 1, 1, lmr_pkg::STATUS_OK, 0, 0));
        add_row(lock_row(lmr_pkg::CMD_ACQUIRE, 63, SEQ_MAX, 0, 1, 1,
                         lmr_pkg::STATUS_RETRY, 0, 1));
        add_row(lock_row(lmr_pkg::CMD_ACQUIRE, 5, 7, 0, 1, 1, lmr_pkg::STATUS_RETRY, 1, 0));
        add_row(lock_row(lmr_pkg::CMD_RELEASE, 63, 0, 0, 1, 1, lmr_pkg::STATUS_OK, 0, 0));
        add_row(lock_row(lmr_pkg::CMD_RELEASE, 0, 0, 0, 1, 1, lmr_pkg::STATUS_OK, 0, 1));
        add_row(lock_row(lmr_pkg::CMD_ACQUIRE, 5, 11, 0, 1, 1, lmr_pkg::STATUS_RETRY, 1, 0));
        add_row(lock_row(lmr_pkg::CMD_ACQUIRE, 63, 9, 0, 1, 1, lmr_pkg::STATUS_OK, 2, 1));
        add_row(lock_row(lmr_pkg::CMD_RELEASE, 63, SEQ_MAX, 0, 1, 0,
                         lmr_pkg::STATUS_OK, 0, 0));
        add_row(lock_row(lmr_pkg::CMD_ACQUIRE, 5, 20, 0, 1, 0, lmr_pkg::STATUS_OK, 0, 0));
        add_row(lock_row(lmr_pkg::CMD_RELEASE, 5, 0, 0, 1, 0, lmr_pkg::STATUS_OK, 0, 0));
        // stale retrier left in place, release with nobody waiting
        add_row(lock_row(lmr_pkg::CMD_ACQUIRE, 9, 30, 0, 1, 1, lmr_pkg::STATUS_OK, 0, 0));
        add_row(lock_row(lmr_pkg::CMD_RELEASE, 9, 0, 0, 1, 1, lmr_pkg::STATUS_OK, 0, 0));
        add_row(lock_row(lmr_pkg::CMD_ACQUIRE, 5, 31, 0, 1, 1, lmr_pkg::STATUS_OK, 0, 0));
        // release of a free lock, release seq not looked at
        add_row(lock_row(lmr_pkg::CMD_RELEASE, 7, 1, 9, 1, 1, lmr_pkg::STATUS_OK, 0, 0));
        add_row(lock_row(lmr_pkg::CMD_ACQUIRE, 63, SEQ_MAX, 255, 1, 1,
                         lmr_pkg::STATUS_OK, 0, 0));
        add_row(lock_row(lmr_pkg::CMD_RELEASE, 63, 12345, 255, 1, 1,
                         lmr_pkg::STATUS_OK, 0, 0));
        // lock 200: fill the queue, refuse one, then grant above the skip threshold
        add_row(lock_row(lmr_pkg::CMD_ACQUIRE, 1, 100, 200, 1, 1, lmr_pkg::STATUS_OK, 0, 0));
        add_row(lock_row(lmr_pkg::CMD_ACQUIRE, 2, 200, 200, 16, 0, lmr_pkg::STATUS_OK, 0, 0));
        add_row(lock_row(lmr_pkg::CMD_ACQUIRE, 40, SEQ_MAX, 200, 1, 1,
                         lmr_pkg::STATUS_FULL, 16, 0));
        add_row(lock_row(lmr_pkg::CMD_RELEASE, 1, 0, 200, 1, 1, lmr_pkg::STATUS_OK, 0, 1));
        add_row(lock_row(lmr_pkg::CMD_ACQUIRE, 2, 200, 200, 1, 1, lmr_pkg::STATUS_OK, 15, 0));
        add_row(lock_row(lmr_pkg::CMD_ACQUIRE, 0, 0, 200, 1, 0, lmr_pkg::STATUS_OK, 0, 0));
        add_row(lock_row(lmr_pkg::CMD_RELEASE, 2, 0, 200, 1, 0, lmr_pkg::STATUS_OK, 0, 0));

        phase_thresh = '{5'd0, 5'd16, 5'd1, 5'd5, 5'd3, 5'd16};
        phase_rel    = '{35, 15, 35, 30, 40, 20};
        phase_thresh[4] = lmr_pkg::THRESH_W'($urandom_range(0, 16));

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i])
        begin
            row = dir_rows[i];
            for (int k = 0; k < int'(row.reps); k++)
                offer(row.cmd, lmr_pkg::CLIENT_W'(int'(row.client) + k),
                      lmr_pkg::SEQ_W'(row.seq + 32'(k)), row.lock_id,
                      row.typed && row.reps == 1, row.t_status, row.t_qlen, row.t_msg);
        end
        settle();

        for (int p = 0; p < 6; p++)
        begin
            write_threshold(phase_thresh[p]);
            // sink holds off for a while so the block backs up onto its input
            if (p == 1)
                long_hold = 1'b1;
            run_mix(PHASE_ITEMS, phase_rel[p]);
            settle();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("lock_manager_revoke_retry_tb: done, clean");
        else
            $display("lock_manager_revoke_retry_tb: done, errors");
        $finish;
    end

endmodule

`default_nettype wire
